### hw/rtl/sha_pkg.sv
// Shared types and constants for the SHA-256 hash engine.
// No dependencies; used by the top level, the front end and the back end.
package sha_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam logic [7:0]  PadByte    = 8'h80;

    typedef logic [31:0] word_t;

    // One queued block for the compression back end.
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } blk_t;

    // Compression sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } cst_t;

    // Front end states.
    typedef enum logic [1:0] {
        FS_GATHER,
        FS_PAD,
        FS_LEN,
        FS_WAIT
    } fst_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        unique case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t init_value(input logic [2:0] i);
        word_t v;
        unique case (i)
            3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab; 3'd7: v = 32'h5be0cd19;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hw/rtl/sha256_hash_engine_unit.sv
// Top level of the SHA-256 hash engine: front end, block register, back end.
// Depends on sha_pkg, sha_front and sha_core.
//
//  Channel | Dir | tdata                                  | tuser
//  s_      | in  | [7:0] msg_byte                         | [0] byte_present, tlast=eom
//  m_      | out | [31:0] digest_word                     | [2:0] word_index, tlast=last
//
// A byte item is taken whenever the input is ready. A full block moves into the
// block register and the input is free again once the back end has taken it;
// the back end runs load, 64 rounds and fold on each block, so a following full
// block waits in the register, with the input stalled, until the back end is idle
// again. A final item costs one or two blocks plus eight output words.
// Reset is synchronous on aresetn and restores the initial hash value.
// Output stalls hold the digest word; the input waits until the digest leaves.
module sha256_hash_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] msg_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);
    import sha_pkg::*;

    logic blk_valid, blk_ready, digest_done;
    blk_t blk_data;

    sha_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_present(s_tuser), .in_eom(s_tlast),
        .blk_valid(blk_valid), .blk_ready(blk_ready), .blk_data(blk_data),
        .digest_done(digest_done)
    );

    sha_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .blk_valid(blk_valid), .blk_ready(blk_ready), .blk_data(blk_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_word(m_tdata), .out_index(m_tuser), .out_last(m_tlast),
        .digest_done(digest_done)
    );
endmodule

### hw/rtl/sha_front.sv
// Front end: gathers bytes into 64-byte blocks and builds the padding blocks.
// Depends on sha_pkg.
module sha_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_present,
    input  logic          in_eom,
    output logic          blk_valid,
    input  logic          blk_ready,
    output sha_pkg::blk_t blk_data,
    input  logic          digest_done
);
    import sha_pkg::*;

    fst_t         st_reg, st_next;
    logic [511:0] buf_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;

    logic         blk_valid_reg;
    blk_t         blk_reg;

    logic [511:0] byte_set;
    logic [511:0] pad_blk;
    logic         accept;

    assign in_ready = (st_reg == FS_GATHER) && !blk_valid_reg;
    assign accept   = in_valid && in_ready;
    assign blk_valid = blk_valid_reg;
    assign blk_data  = blk_reg;

    // Buffer with the incoming byte placed at the fill position (byte 0 at the top).
    always_comb begin
        byte_set = buf_reg;
        byte_set[511 - 8*fill_reg -: 8] = in_byte;
    end

    // Padding: the current bytes, a marker byte and zeros after it.
    always_comb begin
        pad_blk = buf_reg;
        for (int i = 0; i < 64; i++) begin
            if (i == fill_reg) begin
                pad_blk[511 - 8*i -: 8] = PadByte;
            end else if (i > fill_reg) begin
                pad_blk[511 - 8*i -: 8] = 8'h00;
            end
        end
    end

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            FS_GATHER: if (accept && in_eom) st_next = FS_PAD;
            FS_PAD:    if (!blk_valid_reg) st_next = FS_WAIT;
            FS_LEN:    if (!blk_valid_reg) st_next = FS_WAIT;
            FS_WAIT:   if (digest_done) st_next = FS_GATHER;
            default:   st_next = FS_GATHER;
        endcase
        if (st_reg == FS_PAD && !blk_valid_reg && fill_reg >= 6'd56) st_next = FS_LEN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= FS_GATHER;
            fill_reg      <= '0;
            bits_reg      <= '0;
            blk_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (blk_valid_reg && blk_ready) blk_valid_reg <= 1'b0;
            unique case (st_reg)
                FS_GATHER: begin
                    if (accept && in_present) begin
                        buf_reg  <= byte_set;
                        bits_reg <= bits_reg + 64'd8;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63) begin
                            blk_reg.block <= byte_set;
                            blk_reg.last  <= 1'b0;
                            blk_valid_reg <= 1'b1;
                        end
                    end
                end
                FS_PAD: begin
                    if (!blk_valid_reg) begin
                        blk_valid_reg <= 1'b1;
                        if (fill_reg >= 6'd56) begin
                            blk_reg.block <= pad_blk;
                            blk_reg.last  <= 1'b0;
                        end else begin
                            blk_reg.block <= {pad_blk[511:64], bits_reg};
                            blk_reg.last  <= 1'b1;
                        end
                    end
                end
                FS_LEN: begin
                    if (!blk_valid_reg) begin
                        blk_valid_reg <= 1'b1;
                        blk_reg.block <= {448'd0, bits_reg};
                        blk_reg.last  <= 1'b1;
                    end
                end
                FS_WAIT: begin
                    if (digest_done) begin
                        fill_reg <= '0;
                        bits_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### hw/rtl/sha_core.sv
// Back end: 64-round compression, one round a cycle, and digest output.
// Depends on sha_pkg.
module sha_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          blk_valid,
    output logic          blk_ready,
    input  sha_pkg::blk_t blk_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_word,
    output logic [2:0]    out_index,
    output logic          out_last,
    output logic          digest_done
);
    import sha_pkg::*;

    cst_t        st_reg, st_next;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [5:0]  rnd_reg;
    logic        last_reg;
    logic [2:0]  idx_reg;

    word_t s0, s1, wnew, t1, t2, e, a;
    logic  take, fold_done, emit_go;

    assign take      = (st_reg == ST_IDLE) && blk_valid;
    assign blk_ready = (st_reg == ST_IDLE);
    assign out_valid = (st_reg == ST_EMIT);
    assign out_word  = h_reg[idx_reg];
    assign out_index = idx_reg;
    assign out_last  = (idx_reg == 3'd7);
    assign emit_go   = out_valid && out_ready;
    assign digest_done = emit_go && out_last;
    assign fold_done = (st_reg == ST_FOLD);

    // Message schedule and round function.
    always_comb begin
        e    = v_reg[4];
        a    = v_reg[0];
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        t1   = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
             + ((e & v_reg[5]) ^ (~e & v_reg[6])) + round_k(rnd_reg) + w_reg[0];
        t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (blk_valid) st_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) st_next = ST_FOLD;
            ST_FOLD:  st_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (emit_go && out_last) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_IDLE;
            rnd_reg <= '0;
            idx_reg <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_value(3'(i));
        end else begin
            st_reg <= st_next;
            if (take) begin
                rnd_reg  <= '0;
                last_reg <= blk_data.last;
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                for (int i = 0; i < 16; i++) w_reg[i] <= blk_data.block[511 - 32*i -: 32];
            end
            if (st_reg == ST_ROUND) begin
                rnd_reg <= rnd_reg + 6'd1;
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= wnew;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (fold_done) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                idx_reg <= '0;
            end
            if (emit_go) begin
                idx_reg <= idx_reg + 3'd1;
                if (out_last) begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= init_value(3'(i));
                end
            end
        end
    end
endmodule

### hw/rtl/sha_checker.sv
// Port checker for the SHA-256 hash engine, bound to the top level.
// No dependencies beyond the top-level ports.
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    // The last flag marks word seven only.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd7))) else $error("last flag wrong");

    // Word index advances by one after each word that is not the last.
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tuser == $past(m_tuser) + 3'd1))
        else $error("index skip");

    // A stalled word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("word changed under stall");

    // No input is taken while a digest is being sent.
    a_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken during output");
endmodule

bind sha256_hash_engine_unit sha_checker u_sha_checker (.*);
